### hdl/bxc_pkg.sv
`timescale 1ns / 1ps

package bxc_pkg;

  localparam int unsigned KeyDepth  = 256;
  localparam int unsigned RandDepth = 16;

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_ENCRYPT = 2'd1;
  localparam logic [1:0] ACT_DECRYPT = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_HDR_ENC = 2'd1,
    OP_HDR_DEC = 2'd2,
    OP_DATA    = 2'd3
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] addr;
    logic [7:0] value;
    logic [3:0] ridx;
  } op_t;

endpackage

### hdl/bxc_ram.sv
`timescale 1ns / 1ps

module bxc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/block_xor_cipher_with_header_top.sv
`timescale 1ns / 1ps
// an accepted beat passes the held-beat and execute registers into the output register
// throughput: one op and byte per cycle via the one key store read port, unless stalled
// an encrypt beat at block start issues HeaderBytes header beats before its data beat
// and stalls the input while it issues them
// reset: control, key fold and per-entry key valid bits clear at once; no clearing pass

module block_xor_cipher_with_header_top #(
  parameter int unsigned BlockBytes  = 256,
  parameter int unsigned HeaderBytes = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  key_index_i,
  input  logic [7:0]  data_byte_i,
  input  logic [63:0] rand_low_i,
  input  logic [63:0] rand_high_i,
  input  logic        message_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        is_header_o,
  output logic        run_last_o
);

  localparam int unsigned PosBits = $clog2(HeaderBytes + BlockBytes + 1);
  localparam int unsigned PosW    = (PosBits > 8) ? PosBits : 8;
  localparam int unsigned CntBits = $clog2(HeaderBytes);
  localparam int unsigned CntW    = (CntBits > 4) ? CntBits : 4;
  localparam int unsigned KeyAw   = $clog2(bxc_pkg::KeyDepth);

  // held input beat
  logic                  h_valid_q, h_valid_d;
  logic [1:0]            h_action_q;
  logic [7:0]            h_idx_q;
  logic [7:0]            h_byte_q;
  logic [15:0][7:0]      h_rand_q;
  logic                  h_last_q;
  logic [CntW-1:0]       h_cnt_q, h_cnt_d;

  // framing
  logic [PosW-1:0]       pos_q, pos_d;
  logic [CntW-1:0]       rmod_q, rmod_d;

  // issue
  bxc_pkg::op_t          op;
  logic                  op_go;
  logic                  h_done;
  logic                  in_accept;
  logic                  hdr_pos;
  logic [PosW-1:0]       data_off;
  logic [PosW-1:0]       pos_inc;
  logic                  blk_end;
  logic [CntW-1:0]       rmod_inc;

  // execute
  logic                  ex_valid_q;
  bxc_pkg::op_t          ex_q;
  logic                  ex_ready;
  logic                  ex_fire;
  logic                  ex_emits;
  logic                  key_we;
  logic [7:0]            ram_rdata;
  logic [7:0]            key_rd;
  logic                  fwd_hit_q;
  logic [7:0]            fwd_data_q;
  logic                  rd_valid_q;
  logic [bxc_pkg::KeyDepth-1:0] key_valid_q;
  logic [7:0]            fold_q  [bxc_pkg::RandDepth];
  logic [7:0]            brand_q [bxc_pkg::RandDepth];

  // output
  logic                  out_valid_q;
  logic                  out_ready;
  logic [7:0]            out_byte_q;
  logic                  out_hdr_q;
  logic                  out_last_q;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign ex_emits  = (ex_q.kind == bxc_pkg::OP_HDR_ENC) || (ex_q.kind == bxc_pkg::OP_DATA);
  assign ex_fire   = ex_valid_q && (!ex_emits || out_ready);
  assign ex_ready  = !ex_valid_q || ex_fire;
  assign key_we    = ex_fire && (ex_q.kind == bxc_pkg::OP_LOAD);

  assign hdr_pos  = pos_q < PosW'(HeaderBytes);
  assign data_off = pos_q - PosW'(HeaderBytes);
  assign pos_inc  = pos_q + PosW'(1);
  assign blk_end  = h_last_q || (pos_inc == PosW'(HeaderBytes + BlockBytes));
  assign rmod_inc = (rmod_q == CntW'(HeaderBytes - 1)) ? '0 : rmod_q + CntW'(1);

  always_comb begin
    op.kind = bxc_pkg::OP_DATA;
    op.addr = data_off[7:0];
    op.value = h_byte_q;
    op.ridx = rmod_q[3:0];
    op_go   = 1'b0;
    h_done  = 1'b0;
    pos_d   = pos_q;
    rmod_d  = rmod_q;
    h_cnt_d = h_cnt_q;
    if (h_valid_q) begin
      case (h_action_q)
        bxc_pkg::ACT_LOAD: begin
          op.kind  = bxc_pkg::OP_LOAD;
          op.addr  = h_idx_q;
          op.ridx  = h_idx_q[3:0];
          op_go    = ex_ready;
          h_done   = ex_ready;
        end
        bxc_pkg::ACT_ENCRYPT, bxc_pkg::ACT_DECRYPT: begin
          if (hdr_pos && (h_action_q == bxc_pkg::ACT_ENCRYPT)) begin
            op.kind  = bxc_pkg::OP_HDR_ENC;
            op.ridx  = h_cnt_q[3:0];
            op.value = h_rand_q[h_cnt_q[3:0]];
            op_go    = ex_ready;
            if (ex_ready) begin
              if (h_cnt_q == CntW'(HeaderBytes - 1)) begin
                h_cnt_d = '0;
                pos_d   = PosW'(HeaderBytes);
              end else begin
                h_cnt_d = h_cnt_q + CntW'(1);
              end
            end
          end else if (hdr_pos) begin
            op.kind = bxc_pkg::OP_HDR_DEC;
            op.ridx = pos_q[3:0];
            op_go   = ex_ready;
            h_done  = ex_ready;
            if (ex_ready) begin
              pos_d = h_last_q ? '0 : pos_inc;
            end
          end else begin
            op_go  = ex_ready;
            h_done = ex_ready;
            if (ex_ready) begin
              pos_d  = blk_end ? '0 : pos_inc;
              rmod_d = blk_end ? '0 : rmod_inc;
            end
          end
        end
        default: begin
          h_done = 1'b1;
        end
      endcase
    end
  end

  assign in_stall_o = h_valid_q && !h_done;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    h_valid_d = h_valid_q;
    if (in_accept) begin
      h_valid_d = 1'b1;
    end else if (h_done) begin
      h_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_valid_q <= 1'b0;
      h_cnt_q   <= '0;
      pos_q     <= '0;
      rmod_q    <= '0;
    end else begin
      h_valid_q <= h_valid_d;
      h_cnt_q   <= in_accept ? '0 : h_cnt_d;
      pos_q     <= pos_d;
      rmod_q    <= rmod_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      h_action_q <= action_i;
      h_idx_q    <= key_index_i;
      h_byte_q   <= data_byte_i;
      h_rand_q   <= {rand_high_i, rand_low_i};
      h_last_q   <= message_last_i;
    end
  end

  // key store
  bxc_ram #(
    .Width (8),
    .Depth (bxc_pkg::KeyDepth)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (ex_q.addr[KeyAw-1:0]),
    .wdata_i (ex_q.value),
    .re_i    (op_go),
    .raddr_i (op.addr[KeyAw-1:0]),
    .rdata_o (ram_rdata)
  );

  assign key_rd = fwd_hit_q ? fwd_data_q : (rd_valid_q ? ram_rdata : 8'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      fwd_hit_q   <= 1'b0;
      rd_valid_q  <= 1'b0;
      key_valid_q <= '0;
      for (int i = 0; i < bxc_pkg::RandDepth; i++) begin
        fold_q[i] <= 8'd0;
      end
    end else begin
      if (ex_ready) begin
        ex_valid_q <= op_go;
      end
      if (op_go) begin
        fwd_hit_q  <= key_we && (ex_q.addr == op.addr);
        rd_valid_q <= key_valid_q[op.addr[KeyAw-1:0]];
      end
      if (key_we) begin
        key_valid_q[ex_q.addr[KeyAw-1:0]] <= 1'b1;
        fold_q[ex_q.addr[3:0]] <= fold_q[ex_q.addr[3:0]] ^ key_rd ^ ex_q.value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_go) begin
      ex_q       <= op;
      fwd_data_q <= ex_q.value;
    end
    if (ex_fire && (ex_q.kind == bxc_pkg::OP_HDR_ENC)) begin
      brand_q[ex_q.ridx] <= ex_q.value;
    end
    if (ex_fire && (ex_q.kind == bxc_pkg::OP_HDR_DEC)) begin
      brand_q[ex_q.ridx] <= ex_q.value ^ fold_q[ex_q.ridx];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= ex_fire && ex_emits;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_fire && ex_emits) begin
      if (ex_q.kind == bxc_pkg::OP_HDR_ENC) begin
        out_byte_q <= fold_q[ex_q.ridx] ^ ex_q.value;
        out_hdr_q  <= 1'b1;
        out_last_q <= 1'b0;
      end else begin
        out_byte_q <= ex_q.value ^ key_rd ^ brand_q[ex_q.ridx];
        out_hdr_q  <= 1'b0;
        out_last_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign is_header_o = out_hdr_q;
  assign run_last_o  = out_last_q;

endmodule

### sim/tb_block_xor_cipher_with_header_top.sv
`timescale 1ns / 1ps

module tb_block_xor_cipher_with_header_top;

  localparam int unsigned BlockBytes  = 256;
  localparam int unsigned HeaderBytes = 16;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned RandomBeats = 190;
  localparam logic [1:0]  ACT_UNUSED  = 2'd3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_header;
    logic       run_last;
  } cipher_beat_t;

  class xor_cipher_predictor;
    logic [7:0]   key_store [bxc_pkg::KeyDepth];
    logic [7:0]   key_fold [bxc_pkg::RandDepth];
    logic [7:0]   block_rand [bxc_pkg::RandDepth];
    int unsigned  block_pos;
    cipher_beat_t pending_beats [$];
    int unsigned  mismatches;
    int unsigned  n_loads;
    int unsigned  n_checked;
    int unsigned  n_headers;

    function new();
      foreach (key_store[i]) key_store[i] = '0;
      foreach (key_fold[i]) key_fold[i] = '0;
      foreach (block_rand[i]) block_rand[i] = '0;
      block_pos   = 0;
      mismatches  = 0;
      n_loads     = 0;
      n_checked   = 0;
      n_headers   = 0;
    endfunction

    function void step_position(logic last);
      block_pos++;
      if (last || block_pos >= HeaderBytes + BlockBytes) block_pos = 0;
    endfunction

    function void note_beat(logic [1:0] act, logic [7:0] idx, logic [7:0] din,
                            logic [63:0] rlo, logic [63:0] rhi, logic last);
      logic [7:0]   r;
      int unsigned  d;
      cipher_beat_t b;
      case (act)
        bxc_pkg::ACT_LOAD: begin
          n_loads++;
          key_fold[idx[3:0]] ^= key_store[idx] ^ din;
          key_store[idx] = din;
          return;
        end
        bxc_pkg::ACT_ENCRYPT: begin
          if (block_pos < HeaderBytes) begin
            for (int j = 0; j < HeaderBytes; j++) begin
              r = (j % 16 < 8) ? rlo[8*(j%8) +: 8] : rhi[8*(j%8) +: 8];
              block_rand[4'(j)] = r;
              b.out_byte  = key_fold[4'(j)] ^ r;
              b.is_header = 1'b1;
              b.run_last  = 1'b0;
              pending_beats.push_back(b);
            end
            block_pos = HeaderBytes;
          end
        end
        bxc_pkg::ACT_DECRYPT: begin
          if (block_pos < HeaderBytes) begin
            block_rand[4'(block_pos)] = din ^ key_fold[4'(block_pos)];
            step_position(last);
            return;
          end
        end
        default: return;
      endcase
      d = block_pos - HeaderBytes;
      b.out_byte  = din ^ key_store[8'(d)] ^ block_rand[4'(d % HeaderBytes)];
      b.is_header = 1'b0;
      b.run_last  = 1'b1;
      pending_beats.push_back(b);
      step_position(last);
    endfunction

    function void check_beat(logic [7:0] ob, logic hdr, logic rl);
      cipher_beat_t want;
      n_checked++;
      if (hdr === 1'b1) n_headers++;
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output beat: byte %02h header %b last %b", ob, hdr, rl);
        return;
      end
      want = pending_beats.pop_front();
      if (ob !== want.out_byte || hdr !== want.is_header || rl !== want.run_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected byte %02h header %b last %b, got %02h %b %b",
                   want.out_byte, want.is_header, want.run_last, ob, hdr, rl);
      end
    endfunction

    function int unsigned pending();
      return pending_beats.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = bxc_pkg::ACT_LOAD;
  logic [7:0]  key_index_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic [63:0] rand_low_i = '0;
  logic [63:0] rand_high_i = '0;
  logic        message_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        is_header_o;
  logic        run_last_o;

  xor_cipher_predictor pred = new();
  bit          quiet = 1'b0;
  int unsigned beats_sent = 0;
  int unsigned idle_cycles = 0;

  block_xor_cipher_with_header_top #(
    .BlockBytes (BlockBytes),
    .HeaderBytes(HeaderBytes)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .key_index_i   (key_index_i),
    .data_byte_i   (data_byte_i),
    .rand_low_i    (rand_low_i),
    .rand_high_i   (rand_high_i),
    .message_last_i(message_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .is_header_o   (is_header_o),
    .run_last_o    (run_last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 11);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      pred.check_beat(out_byte_o, is_header_o, run_last_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("no progress for %0d cycles, %0d beats still expected",
               idle_cycles, pred.pending());
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_beat(logic [1:0] act, logic [7:0] idx, logic [7:0] din,
                           logic [63:0] rlo, logic [63:0] rhi, logic last);
    if (!quiet && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    action_i       <= act;
    key_index_i    <= idx;
    data_byte_i    <= din;
    rand_low_i     <= rlo;
    rand_high_i    <= rhi;
    message_last_i <= last;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pred.note_beat(act, idx, din, rlo, rhi, last);
    if (act != ACT_UNUSED) beats_sent++;
  endtask

  task automatic load_key(logic [7:0] idx, logic [7:0] val);
    send_beat(bxc_pkg::ACT_LOAD, idx, val, rand64(), rand64(), 1'($urandom_range(1)));
  endtask

  task automatic send_message(logic [1:0] act, int unsigned len, bit with_last);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) load_key(8'($urandom), 8'($urandom));
      send_beat(act, 8'($urandom), 8'($urandom), rand64(), rand64(),
                with_last && (i == len - 1));
    end
  endtask

  initial begin
    int unsigned base;
    int unsigned pick;
    int unsigned len;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extremes of key index and data
    load_key(8'h00, 8'hFF);
    load_key(8'hFF, 8'hA5);
    send_beat(ACT_UNUSED, 8'hFF, 8'hFF, '1, '1, 1'b1);
    // encrypt: header burst then continuing data, then message end
    send_beat(bxc_pkg::ACT_ENCRYPT, 8'h00, 8'h00, '1, '0, 1'b0);
    send_beat(bxc_pkg::ACT_ENCRYPT, 8'hFF, 8'hFF, '0, '1, 1'b1);
    // partial decrypt header interrupted by an encrypt
    send_beat(bxc_pkg::ACT_DECRYPT, 8'h00, 8'h00, '0, '0, 1'b0);
    send_beat(bxc_pkg::ACT_DECRYPT, 8'h00, 8'hFF, '0, '0, 1'b0);
    send_beat(bxc_pkg::ACT_DECRYPT, 8'h00, 8'h5A, '0, '0, 1'b0);
    send_beat(bxc_pkg::ACT_ENCRYPT, 8'h00, 8'hFF, '0, '1, 1'b1);
    // full decrypt header then one data beat
    for (int i = 0; i < HeaderBytes; i++)
      send_beat(bxc_pkg::ACT_DECRYPT, 8'h00, (i % 2) ? 8'hFF : 8'h00, '0, '0, 1'b0);
    send_beat(bxc_pkg::ACT_DECRYPT, 8'h00, 8'h81, '0, '0, 1'b1);
    send_message(bxc_pkg::ACT_ENCRYPT, 1, 1'b1);

    base = beats_sent;
    while (beats_sent < base + RandomBeats) begin
      quiet = (beats_sent - base >= 60) && (beats_sent - base < 120);
      pick = $urandom_range(99);
      if (pick < 20) begin
        repeat ($urandom_range(1, 4)) load_key(8'($urandom), 8'($urandom));
      end else if (pick < 25) begin
        send_beat(ACT_UNUSED, 8'($urandom), 8'($urandom), rand64(), rand64(),
                  1'($urandom_range(1)));
      end else if (pick < 60) begin
        send_message(bxc_pkg::ACT_ENCRYPT, $urandom_range(1, 12), $urandom_range(99) < 85);
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(1, HeaderBytes - 1)
                                       : HeaderBytes + $urandom_range(1, 12);
        send_message(bxc_pkg::ACT_DECRYPT, len, $urandom_range(99) < 85);
      end
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    while (pred.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (pred.pending() != 0) pred.mismatches++;
    $display("sent %0d beats (%0d key loads) over short messages and partial blocks",
             beats_sent, pred.n_loads);
    $display("checked %0d output beats, %0d of them header bytes, %0d mismatches",
             pred.n_checked, pred.n_headers, pred.mismatches);
    if (pred.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
